### rtl/sha1_pkg.sv
package sha1_pkg;

  localparam logic [1:0] CmdRestart = 2'd0;
  localparam logic [1:0] CmdByte    = 2'd1;
  localparam logic [1:0] CmdFinish  = 2'd2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } round_req_t;

  function automatic logic [31:0] round_f(input logic [6:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (i < 7'd20) begin
      return (b & c) | (~b & d);
    end else if (i < 7'd40) begin
      return b ^ c ^ d;
    end else if (i < 7'd60) begin
      return (b & c) | (b & d) | (c & d);
    end else begin
      return b ^ c ^ d;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] i);
    if (i < 7'd20) begin
      return K0;
    end else if (i < 7'd40) begin
      return K1;
    end else if (i < 7'd60) begin
      return K2;
    end else begin
      return K3;
    end
  endfunction

endpackage

### rtl/sha1_byte_stream_digest_core.sv
// Channel  Dir  tdata fields (low first)                      tuser
// s_axis   in   cmd[1:0], data_byte[9:2]                       -
// m_axis   out  digest_w0..digest_w4 (w0 lowest, 160 bits)     digest_ok
// A byte is taken as a memory write, then a fill update, before the next item
// is ready. A full block then runs a start, a word fetch from the block memory,
// 80 rounds and the take-up of the new chaining words.
// Finish on an open message pads one byte per cycle, writes the eight
// length bytes and runs one or two compressions. Reset is synchronous; no
// item is taken while the digest beat waits.
module sha1_byte_stream_digest_core
  import sha1_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // cmd, data_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // digest_w0 .. digest_w4
  output logic         m_axis_tuser    // digest_ok
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_BYTE, ST_PAD, ST_LEN, ST_COMP, ST_OUT
  } state_t;

  state_t      state;
  logic [31:0] mem [16];
  logic [31:0] rd_word;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        wr_en;
  logic [6:0]  fill;
  logic [63:0] bit_len;
  logic        fin, err;
  logic        pad_two;
  logic        after_final;
  logic        pad_pending;
  logic [31:0] h0, h1, h2, h3, h4;
  round_req_t  req;
  logic [3:0]  wrd_addr;
  logic        done;
  logic [31:0] r_a, r_b, r_c, r_d, r_e;
  logic [1:0]  cmd;
  logic [7:0]  dbyte;
  logic [63:0] len_next;

  assign cmd = s_axis_tdata[1:0];
  assign dbyte = s_axis_tdata[9:2];
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign len_next = bit_len + 64'd8;

  // Byte memory, read as big-endian 32-bit words by the round unit.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
    end
    rd_word <= mem[wrd_addr];
  end

  sha1_rounds u_rounds (
    .clk(clk), .rst(rst), .req(req), .wrd_addr(wrd_addr), .wrd_data(rd_word),
    .done(done), .h_a(r_a), .h_b(r_b), .h_c(r_c), .h_d(r_d), .h_e(r_e)
  );

  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill[5:0];
    wr_data = dbyte;
    if (state == ST_IDLE && s_axis_tvalid && cmd == CmdByte && !fin && !err) begin
      wr_en = 1'b1;
    end else if (state == ST_PAD) begin
      wr_en = !fill[6];
      wr_data = 8'd0;
    end else if (state == ST_LEN) begin
      wr_en = 1'b1;
      wr_data = bit_len[8'd63 - {2'd0, fill[2:0], 3'd0} -: 8];
      wr_addr = {3'b111, fill[2:0]};
    end
    if (state == ST_IDLE && s_axis_tvalid && cmd == CmdFinish && !fin && !err) begin
      wr_en = 1'b1;
      wr_data = PadByte;
    end
  end

  always_ff @(posedge clk) begin
    req.start <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0; bit_len <= '0; fin <= 1'b0; err <= 1'b0;
      h0 <= H0; h1 <= H1; h2 <= H2; h3 <= H3; h4 <= H4;
      pad_two <= 1'b0; after_final <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (cmd)
              CmdRestart: begin
                fill <= '0; bit_len <= '0; fin <= 1'b0; err <= 1'b0;
                h0 <= H0; h1 <= H1; h2 <= H2; h3 <= H3; h4 <= H4;
              end
              CmdByte: begin
                if (fin || err) begin
                  err <= 1'b1;
                end else begin
                  bit_len <= len_next;
                  if (len_next == 64'd0) begin
                    err <= 1'b1;
                  end
                  state <= ST_BYTE;
                end
              end
              CmdFinish: begin
                if (err || fin) begin
                  state <= ST_OUT;
                end else begin
                  pad_two <= (fill > 7'd55);
                  fill <= fill + 7'd1;
                  state <= ST_PAD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_BYTE: begin
          if (fill == 7'd63) begin
            fill <= '0;
            after_final <= 1'b0;
            req <= '{1'b1, h0, h1, h2, h3, h4};
            state <= ST_COMP;
          end else begin
            fill <= fill + 7'd1;
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          if (pad_two) begin
            if (fill[6]) begin
              fill <= '0;
              pad_two <= 1'b0;
              after_final <= 1'b0;
              req <= '{1'b1, h0, h1, h2, h3, h4};
              state <= ST_COMP;
            end else begin
              fill <= fill + 7'd1;
            end
          end else if (fill >= 7'd55) begin
            fill <= '0;
            state <= ST_LEN;
          end else begin
            fill <= fill + 7'd1;
          end
        end
        ST_LEN: begin
          fill <= fill + 7'd1;
          if (fill[2:0] == 3'd7) begin
            fill <= '0;
            after_final <= 1'b1;
            req <= '{1'b1, h0, h1, h2, h3, h4};
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (done) begin
            h0 <= r_a; h1 <= r_b; h2 <= r_c; h3 <= r_d; h4 <= r_e;
            if (after_final) begin
              fin <= 1'b1;
              state <= ST_OUT;
            end else begin
              state <= (fill == 7'd0 && pad_pending) ? ST_PAD : ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A two-block finish resumes padding after the first compression.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_pending <= 1'b0;
    end else if (state == ST_PAD && pad_two && fill[6]) begin
      pad_pending <= 1'b1;
    end else if (state == ST_COMP && done) begin
      pad_pending <= 1'b0;
    end
  end

  always_comb begin
    if (err) begin
      m_axis_tdata = '0;
      m_axis_tuser = 1'b0;
    end else begin
      m_axis_tdata = {h4, h3, h2, h1, h0};
      m_axis_tuser = 1'b1;
    end
  end

endmodule

### rtl/sha1_rounds.sv
module sha1_rounds
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  round_req_t  req,
  output logic [3:0]  wrd_addr,
  input  logic [31:0] wrd_data,
  output logic        done,
  output logic [31:0] h_a,
  output logic [31:0] h_b,
  output logic [31:0] h_c,
  output logic [31:0] h_d,
  output logic [31:0] h_e
);

  // Block words arrive from the buffer memory in the cycle after their wrd_addr.
  // The 16-word schedule window is a shift line.
  logic [31:0] w [16];
  logic [6:0]  rnd;
  logic        busy;
  logic        fetch;
  logic [4:0]  fcnt;
  logic [31:0] a, b, c, d, e;
  logic [31:0] wi, t;
  logic [31:0] wx;

  assign wrd_addr = fcnt[3:0];
  assign wx = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wi = (rnd < 7'd16) ? w[rnd[3:0]] : {wx[30:0], wx[31]};
  assign t = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + wi + round_k(rnd);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy  <= 1'b0;
      fetch <= 1'b0;
      fcnt  <= '0;
      rnd   <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      fetch <= 1'b1;
      fcnt  <= '0;
      rnd   <= '0;
      a <= req.a; b <= req.b; c <= req.c; d <= req.d; e <= req.e;
      h_a <= req.a; h_b <= req.b; h_c <= req.c; h_d <= req.d; h_e <= req.e;
    end else if (fetch) begin
      fcnt <= fcnt + 5'd1;
      if (fcnt != 5'd0) begin
        w[fcnt[3:0] - 4'd1] <= wrd_data;
      end
      if (fcnt == 5'd16) begin
        fetch <= 1'b0;
      end
    end else if (busy) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      if (rnd >= 7'd16) begin
        for (int j = 0; j < 15; j++) begin
          w[j] <= w[j + 1];
        end
        w[15] <= wi;
      end
      rnd <= rnd + 7'd1;
      if (rnd == 7'd79) begin
        busy <= 1'b0;
        done <= 1'b1;
        h_a <= h_a + t;
        h_b <= h_b + a;
        h_c <= h_c + {b[1:0], b[31:2]};
        h_d <= h_d + c;
        h_e <= h_e + d;
      end
    end
  end

endmodule

### tb/sha1_byte_stream_digest_core_tb.sv
`timescale 1ns / 1ps

module sha1_byte_stream_digest_core_tb;
  import sha1_pkg::*;

  localparam logic [1:0] CmdNop = 2'd3;

  typedef struct packed {
    logic        ok;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } digest_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;
  logic         m_axis_tuser;

  sha1_byte_stream_digest_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] bit_len;
  bit          finished;
  bit          err;

  digest_t     digest_q [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;
  bit          failed;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rotl(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    fill = 0;
  endtask

  task automatic clear_message();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    fill = 0;
    bit_len = '0;
    finished = 1'b0;
    err = 1'b0;
  endtask

  task automatic predict_digest(logic [1:0] cmd, logic [7:0] data);
    int unsigned pos;
    digest_t r;
    case (cmd)
      CmdRestart: clear_message();
      CmdByte: begin
        if (finished || err) begin
          err = 1'b1;
        end else begin
          blk[fill] = data;
          fill++;
          bit_len += 64'd8;
          if (bit_len == '0) err = 1'b1;
          if (fill == 64) compress();
        end
      end
      CmdFinish: begin
        if (err) begin
          r = '0;
        end else begin
          if (!finished) begin
            pos = fill;
            blk[pos] = PadByte;
            pos++;
            if (pos > 56) begin
              while (pos < 64) begin
                blk[pos] = 8'h00;
                pos++;
              end
              compress();
              pos = 0;
            end
            while (pos < 56) begin
              blk[pos] = 8'h00;
              pos++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
            compress();
            finished = 1'b1;
          end
          r = {1'b1, chain[0], chain[1], chain[2], chain[3], chain[4]};
        end
        digest_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] cmd, logic [7:0] data);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, data, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_digest(cmd, data);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(CmdByte, 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(CmdFinish, 8'h00);
    send_item(CmdFinish, 8'hFF);
    send_item(CmdRestart, 8'h00);
    send_item(CmdByte, 8'h61);
    send_item(CmdByte, 8'h62);
    send_item(CmdByte, 8'h63);
    send_item(CmdNop, 8'hAA);
    send_item(CmdFinish, 8'h00);
    send_item(CmdByte, 8'hFF);
    send_item(CmdFinish, 8'h55);
    send_item(CmdRestart, 8'hFF);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'hFF);
    send_item(CmdFinish, 8'h00);
    send_item(CmdRestart, 8'h00);
  endtask

  task automatic test_lengths();
    int unsigned lens [8] = '{55, 56, 57, 63, 64, 65, 119, 128};
    foreach (lens[i]) begin
      send_item(CmdRestart, 8'($urandom));
      send_message(lens[i]);
      send_item(CmdFinish, 8'($urandom));
    end
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        send_item(CmdRestart, 8'($urandom));
        len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(70);
        send_message(len);
        send_item(CmdFinish, 8'($urandom));
        sent += len + 2;
        if ($urandom_range(3) == 0) begin
          send_item(CmdFinish, 8'($urandom));
          sent++;
        end
        if ($urandom_range(5) == 0) begin
          send_item(CmdByte, 8'($urandom));
          send_item(CmdFinish, 8'($urandom));
          sent += 2;
        end
      end else begin
        send_item(2'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 3000;
    send_item(CmdRestart, 8'h00);
    for (int i = 0; i < 10; i++) begin
      send_message($urandom_range(20));
      send_item(CmdFinish, 8'($urandom));
    end
    drain();
  endtask

  task automatic run_phase(int idle, int stall, int unsigned n_items);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    test_random(n_items);
    drain();
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    digest_t got;
    digest_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tdata[159:128]};
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat %h", $time, got);
        failed = 1'b1;
      end else begin
        want = digest_q.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
          failed = 1'b1;
        end
        if (got.w0 !== want.w0) begin
          $display("%0t: w0 expected %h actual %h", $time, want.w0, got.w0);
          failed = 1'b1;
        end
        if (got.w1 !== want.w1) begin
          $display("%0t: w1 expected %h actual %h", $time, want.w1, got.w1);
          failed = 1'b1;
        end
        if (got.w2 !== want.w2) begin
          $display("%0t: w2 expected %h actual %h", $time, want.w2, got.w2);
          failed = 1'b1;
        end
        if (got.w3 !== want.w3) begin
          $display("%0t: w3 expected %h actual %h", $time, want.w3, got.w3);
          failed = 1'b1;
        end
        if (got.w4 !== want.w4) begin
          $display("%0t: w4 expected %h actual %h", $time, want.w4, got.w4);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    failed          = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    clear_message();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_lengths();
    drain();
    test_backpressure();
    run_phase(0, 0, 250);
    run_phase(85, 0, 125);
    run_phase(0, 85, 125);
    run_phase(15, 15, 250);
    if (!failed && digest_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (digest_q.size() != 0) begin
        $display("%0t: %0d digests never arrived", $time, digest_q.size());
      end
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
